/* rtl/core/s256_pkg.sv */
// Shared constants, types and round tables for the SHA-256 byte-stream hasher.
package s256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_START   = 56;
    localparam int ROUNDS      = 64;
    localparam int CHAIN_WORDS = 8;

    localparam logic [5:0] FILL_LAST    = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] FILL_PAD_END = 6'(LEN_START - 1);
    localparam logic [5:0] ROUND_LAST   = 6'(ROUNDS - 1);
    localparam logic [2:0] WORD_LAST    = 3'(CHAIN_WORDS - 1);

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    typedef logic [1:0] s256_bsel_t;
    localparam s256_bsel_t BSEL_DATA = 2'd0;
    localparam s256_bsel_t BSEL_PAD  = 2'd1;
    localparam s256_bsel_t BSEL_ZERO = 2'd2;
    localparam s256_bsel_t BSEL_LEN  = 2'd3;

    typedef struct packed {
        logic       shift_en;
        s256_bsel_t byte_sel;
        logic       len_load;
        logic       round_start;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_update;
        logic       chain_reset;
        logic [2:0] out_idx;
    } s256_cmd_t;

    typedef struct packed {
        logic [5:0] fill_count;
    } s256_stat_t;

    localparam logic [31:0] INIT_HASH [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* rtl/core/s256_datapath.sv */
// Datapath: message window, round registers, chaining words and bit counter.
module s256_datapath
    import s256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  s256_cmd_t   cmd,
    input  logic [7:0]  data_byte,
    output s256_stat_t  stat,
    output logic [31:0] digest_word
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg [8];
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [5:0]  fill_reg;

    logic [7:0]  byte_in;
    logic [31:0] sched_s0;
    logic [31:0] sched_s1;
    logic [31:0] sched_new;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        unique case (cmd.byte_sel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_PAD:  byte_in = PAD_BYTE;
            BSEL_ZERO: byte_in = 8'd0;
            BSEL_LEN:  byte_in = len_reg[63:56];
            default:   byte_in = 8'd0;
        endcase
    end

    // Message schedule: w_reg[0] is W[t] in round t.
    assign sched_s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign sched_s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign sched_new = sched_s1 + w_reg[9] + sched_s0 + w_reg[0];

    assign big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + ROUND_K[cmd.round_idx] + w_reg[0];
    assign big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_next[i] = w_reg[i];
        end
        if (cmd.shift_en) begin
            // Shift the whole block left by one byte, big-endian within words.
            for (int i = 0; i < 15; i++) begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], byte_in};
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = sched_new;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            v_next[i] = v_reg[i];
        end
        if (cmd.round_start) begin
            for (int i = 0; i < 8; i++) begin
                v_next[i] = h_reg[i];
            end
        end else if (cmd.round_en) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            w_reg[i] <= w_next[i];
        end
        for (int i = 0; i < 8; i++) begin
            v_reg[i] <= v_next[i];
        end
        if (cmd.len_load) begin
            len_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
        end else if (cmd.shift_en && cmd.byte_sel == BSEL_LEN) begin
            len_reg <= {len_reg[55:0], 8'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.chain_reset) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= INIT_HASH[i];
            end
            bits_reg <= 64'd0;
            fill_reg <= 6'd0;
        end else begin
            if (cmd.chain_update) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
                bits_reg <= bits_reg + BLOCK_BITS;
            end
            // Wraps to zero as the 64th byte lands.
            if (cmd.shift_en) begin
                fill_reg <= fill_reg + 6'd1;
            end
        end
    end

    assign stat.fill_count = fill_reg;
    assign digest_word     = h_reg[cmd.out_idx];

endmodule

/* rtl/core/s256_ctrl.sv */
// Controller: absorb, padding, round sequencing and digest output.
module s256_ctrl
    import s256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output logic       m_last_word,
    input  s256_stat_t stat,
    output s256_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD80 = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] ret_reg;
    logic [2:0] ret_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    always_comb begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        round_next       = round_reg;
        idx_next         = idx_reg;
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        cmd              = '0;
        cmd.byte_sel     = BSEL_DATA;
        cmd.round_idx    = round_reg;
        cmd.out_idx      = idx_reg;

        unique case (state_reg) inside
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_action) begin
                        cmd.shift_en = 1'b1;
                        if (stat.fill_count == FILL_LAST) begin
                            cmd.round_start = 1'b1;
                            round_next      = 6'd0;
                            ret_next        = ST_IDLE;
                            state_next      = ST_ROUND;
                        end
                    end else begin
                        cmd.len_load = 1'b1;
                        state_next   = ST_PAD80;
                    end
                end
            end
            ST_PAD80, ST_ZERO: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = (state_reg == ST_PAD80) ? BSEL_PAD : BSEL_ZERO;
                if (stat.fill_count == FILL_LAST) begin
                    // No room for the length: compress, then pad a fresh block.
                    cmd.round_start = 1'b1;
                    round_next      = 6'd0;
                    ret_next        = ST_ZERO;
                    state_next      = ST_ROUND;
                end else if (stat.fill_count == FILL_PAD_END) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_LEN: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BSEL_LEN;
                if (stat.fill_count == FILL_LAST) begin
                    cmd.round_start = 1'b1;
                    round_next      = 6'd0;
                    ret_next        = ST_OUT;
                    state_next      = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.chain_update = 1'b1;
                idx_next         = 3'd0;
                state_next       = ret_reg;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == WORD_LAST) begin
                        cmd.chain_reset = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= 6'd0;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == WORD_LAST);

endmodule

/* rtl/core/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte-stream hasher.
// Feeds a message one byte per input word (action 0) and closes it with a finish
// word (action 1); the finish returns the 256-bit digest as eight 32-bit output
// words, index 0 most significant, then the hasher is back in its initial state.
// An absorb word is taken straight into the block window; the 64th byte of a block
// starts a compression of 64 rounds on a single round unit, followed by a fold into
// the chaining words. A finish shifts one pad or length byte per cycle into the block
// window, except while a block compresses: the last block alone holds the length when
// n < 56 bytes are pending, else an extra block is needed, followed by the eight
// digest words. No input is taken while a block compresses, padding runs or the
// digest is being read out.
module sha256_byte_stream_hasher
    import s256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    s256_cmd_t  cmd;
    s256_stat_t stat;

    s256_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .stat         (stat),
        .cmd          (cmd)
    );

    s256_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data_byte),
        .stat        (stat),
        .digest_word (m_digest_word)
    );

    // Input and output never open at once.
    assert property (@(posedge aclk) disable iff (!aresetn) !(m_valid && s_ready))
        else $error("input ready while digest pending");

    // Digest words come out in order without gaps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word)
        |=> (m_valid && m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest word sequence broken");

    // After the final word the hasher is idle with an empty block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && stat.fill_count == 6'd0))
        else $error("hasher not idle after digest");

    // A block never starts compressing unless the window is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_start |-> (cmd.shift_en && stat.fill_count == FILL_LAST))
        else $error("compression started on a partial block");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the SHA-256 byte-stream hasher with its own digest predictor.
module tb_top;
    import s256_pkg::*;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam int ITEM_TARGET  = 260;
    localparam int MSG_MINIMUM  = 8;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 300;
    localparam int REPORT_MAX   = 10;

    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam int         LEN_FIELD = 56;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_action    = ACT_ABSORB;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    // predictor state
    logic [31:0] hash_state [8];
    logic [63:0] msg_bit_len;
    logic [7:0]  blk_buf [64];
    int unsigned blk_fill;

    digest_word_t digest_q [$];

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned msgs_done     = 0;
    int unsigned words_checked = 0;
    int unsigned send_calm     = 0;
    int unsigned ready_hold    = 0;
    int unsigned ready_calm    = 0;

    sha256_byte_stream_hasher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void reset_hash();
        foreach (hash_state[i]) hash_state[i] = SHA_IV[i];
        foreach (blk_buf[i]) blk_buf[i] = 8'h00;
        msg_bit_len = 64'd0;
        blk_fill    = 0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        foreach (hash_state[i]) hash_state[i] += v[i];
    endfunction

    // Advance the hash for one accepted word; a finish queues the eight digest words.
    function automatic void hash_word(logic act, logic [7:0] dbyte);
        int unsigned pos;
        digest_word_t dw;
        if (act == ACT_ABSORB) begin
            blk_buf[blk_fill] = dbyte;
            blk_fill++;
            if (blk_fill == 64) begin
                compress_block();
                msg_bit_len += 64'd512;
                blk_fill = 0;
            end
            return;
        end
        pos = blk_fill;
        msg_bit_len += 64'(pos) * 64'd8;
        blk_buf[pos] = PAD_MARK;
        pos++;
        // no room left for the length field: close this block first
        if (pos > LEN_FIELD) begin
            while (pos < 64) begin
                blk_buf[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < LEN_FIELD) begin
            blk_buf[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk_buf[LEN_FIELD + i] = msg_bit_len[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.idx  = 3'(i);
            dw.last = (i == 7);
            digest_q.push_back(dw);
        end
        reset_hash();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("tb_top: ERROR at %0t: %s", $realtime, msg);
    endtask

    // Hold valid across back-to-back words; drop it only for a gap.
    task automatic send_word(logic act, logic [7:0] dbyte);
        int unsigned gap;
        if (send_calm != 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0)
                send_calm = $urandom_range(20, 80);
        end
        if (gap != 0) begin
            s_valid     <= 1'b0;
            s_action    <= 1'($urandom);
            s_data_byte <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_byte <= dbyte;
        do @(posedge aclk); while (!s_ready);
        hash_word(act, dbyte);
        items_sent++;
        if (act == ACT_ABSORB)
            bytes_sent++;
        else
            msgs_done++;
    endtask

    task automatic send_message(int unsigned len, int fill_kind);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            case (fill_kind)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default:   b = 8'($urandom);
            endcase
            send_word(ACT_ABSORB, b);
        end
        send_word(ACT_FINISH, 8'($urandom));
    endtask

    task automatic test_empty_message();
        send_word(ACT_FINISH, 8'h00);
        send_word(ACT_FINISH, 8'hff);
    endtask

    task automatic test_extreme_bytes();
        send_message(1, FILL_ZERO);
        send_message(1, FILL_ONES);
        send_word(ACT_ABSORB, 8'hff);
        send_word(ACT_ABSORB, 8'h00);
        send_word(ACT_ABSORB, 8'h55);
        send_word(ACT_ABSORB, 8'haa);
        send_word(ACT_FINISH, 8'h00);
    endtask

    task automatic test_known_abc();
        send_word(ACT_ABSORB, 8'h61);
        send_word(ACT_ABSORB, 8'h62);
        send_word(ACT_ABSORB, 8'h63);
        send_word(ACT_FINISH, 8'hff);
    endtask

    // Lengths lean on the padding edges: 55/56 pending and full 64-byte blocks.
    task automatic test_random_messages();
        int unsigned len;
        int fill_kind;
        while (items_sent < ITEM_TARGET || msgs_done < MSG_MINIMUM) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 8);
                1:       len = 55;
                2:       len = 56;
                3:       len = 63;
                4:       len = 64;
                5:       len = $urandom_range(57, 62);
                default: len = $urandom_range(0, 127);
            endcase
            // trim the last message so the word count lands on the target
            if (items_sent + len >= ITEM_TARGET)
                len = (items_sent < ITEM_TARGET) ? ITEM_TARGET - items_sent - 1 : 0;
            case ($urandom_range(0, 9))
                0:       fill_kind = FILL_ZERO;
                1:       fill_kind = FILL_ONES;
                default: fill_kind = FILL_RANDOM;
            endcase
            send_message(len, fill_kind);
        end
    endtask

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            if (ready_calm != 0) begin
                ready_calm--;
            end else begin
                ready_hold = pick_gap();
                if ($urandom_range(0, 49) == 0)
                    ready_calm = $urandom_range(30, 120);
            end
        end
    end

    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                flag_error($sformatf("unexpected digest word %h idx %0d last %b",
                    m_digest_word, m_word_index, m_last_word));
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (m_digest_word !== want.word || m_word_index !== want.idx ||
                    m_last_word !== want.last)
                    flag_error($sformatf(
                        "digest word: want %h idx %0d last %b, got %h idx %0d last %b",
                        want.word, want.idx, want.last,
                        m_digest_word, m_word_index, m_last_word));
            end
        end
    end

    initial begin
        int unsigned drain;
        reset_hash();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_extreme_bytes();
        test_known_abc();
        test_random_messages();
        s_valid <= 1'b0;

        drain = 0;
        while (digest_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (digest_q.size() != 0)
            flag_error($sformatf("%0d digest words never arrived", digest_q.size()));

        $display("tb_top: %0d messages hashed from %0d bytes, %0d digest words checked",
            msgs_done, bytes_sent, words_checked);
        $display("tb_top: %0d errors counted", err_count);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/s256_pkg.sv
rtl/core/s256_datapath.sv
rtl/core/s256_ctrl.sv
rtl/core/sha256_byte_stream_hasher.sv
tb/tb_top.sv
